FILE: hw/rtl/u16u8_pkg.sv
// Shared types and byte-encoding functions for the UTF-16 to UTF-8 encoder.
// Used by u16u8_front, u16u8_queue, u16u8_back and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package u16u8_pkg;

    // Number of slots in the queue between the front and the back part
    localparam int unsigned QueueDepth = 2;

    // UTF-8 lead and continuation markers
    localparam logic [7:0] Lead2 = 8'hC0;
    localparam logic [7:0] Lead3 = 8'hE0;
    localparam logic [7:0] Lead4 = 8'hF0;
    localparam logic [7:0] Cont  = 8'h80;

    // Surrogate classes, taken from the top six bits of a code unit
    localparam logic [5:0] HighSurrTag = 6'b110110;
    localparam logic [5:0] LowSurrTag  = 6'b110111;

    // Base of the supplementary planes
    localparam logic [20:0] SuppBase = 21'h10000;

    // One queued work item: an optional held high surrogate sent alone,
    // followed by an optional code point
    typedef struct packed {
        logic        has_held;
        logic [9:0]  held_bits;
        logic        has_main;
        logic [20:0] main_cp;
        logic        eos;
    } u16u8_entry_t;

    // Index of the last byte of the UTF-8 sequence for a code point
    function automatic logic [1:0] last_idx(input logic [20:0] cp);
        logic [1:0] idx;
        if (cp < 21'h80) begin
            idx = 2'd0;
        end else if (cp < 21'h800) begin
            idx = 2'd1;
        end else if (cp < 21'h10000) begin
            idx = 2'd2;
        end else begin
            idx = 2'd3;
        end
        return idx;
    endfunction

    // Byte k of the UTF-8 sequence for cp, whose last byte index is li
    function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic [1:0] li,
                                            input logic [1:0] k);
        logic [7:0] b;
        b = 8'h00;
        case (li)
            2'd0: b = cp[7:0];
            2'd1: b = (k == 2'd0) ? (Lead2 | {3'b000, cp[10:6]}) : (Cont | {2'b00, cp[5:0]});
            2'd2:
            begin
                case (k)
                    2'd0:    b = Lead3 | {4'b0000, cp[15:12]};
                    2'd1:    b = Cont | {2'b00, cp[11:6]};
                    default: b = Cont | {2'b00, cp[5:0]};
                endcase
            end
            default:
            begin
                case (k)
                    2'd0:    b = Lead4 | {5'b00000, cp[20:18]};
                    2'd1:    b = Cont | {2'b00, cp[17:12]};
                    2'd2:    b = Cont | {2'b00, cp[11:6]};
                    default: b = Cont | {2'b00, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/u16u8_front.sv
// Front part: accepts code units, tracks a held high surrogate, and builds queue entries.
// Depends on u16u8_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u16u8_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   code_valid,
    output logic                        code_stall,
    input  wire logic [15:0]            code_unit,
    input  wire logic                   end_of_string,
    input  wire logic                   q_full,
    output logic                        q_push,
    output u16u8_pkg::u16u8_entry_t     q_entry
);
    import u16u8_pkg::*;

    logic       held_valid_reg;
    logic       held_valid_next;
    logic [9:0] held_bits_reg;
    logic [9:0] held_bits_next;
    logic       accept;
    logic       is_high;
    logic       is_low;
    logic       keep_high;

    assign code_stall = q_full;
    assign accept     = code_valid && !q_full;
    assign is_high    = (code_unit[15:10] == HighSurrTag);
    assign is_low     = (code_unit[15:10] == LowSurrTag);
    assign keep_high  = is_high && !end_of_string;

    // Classify the unit against the held surrogate
    always_comb
    begin
        q_entry.held_bits = held_bits_reg;
        q_entry.eos       = end_of_string;
        held_valid_next   = held_valid_reg;
        held_bits_next    = held_bits_reg;
        if (held_valid_reg && is_low) begin
            // pair completes: one supplementary code point
            q_entry.has_held = 1'b0;
            q_entry.has_main = 1'b1;
            q_entry.main_cp  = {1'b0, held_bits_reg, code_unit[9:0]} + SuppBase;
        end else begin
            q_entry.has_held = held_valid_reg;
            q_entry.has_main = !keep_high;
            q_entry.main_cp  = {5'b00000, code_unit};
        end
        if (accept) begin
            held_valid_next = !(held_valid_reg && is_low) && keep_high;
            held_bits_next  = held_valid_next ? code_unit[9:0] : 10'd0;
        end
    end

    // Push only items that produce bytes
    assign q_push = accept && (q_entry.has_held || q_entry.has_main);

    // Hold surrogate state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_valid_reg <= 1'b0;
            held_bits_reg  <= 10'd0;
        end else begin
            held_valid_reg <= held_valid_next;
            held_bits_reg  <= held_bits_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/u16u8_queue.sv
// Short queue of work entries between the front and the back part.
// Depends on u16u8_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u16u8_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire u16u8_pkg::u16u8_entry_t push_entry,
    input  wire logic                   pop,
    output logic                        full,
    output logic                        head_valid,
    output u16u8_pkg::u16u8_entry_t     head_entry
);
    import u16u8_pkg::*;

    localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int unsigned CntW = $clog2(QueueDepth + 1);
    localparam logic [CntW-1:0] DepthCnt = CntW'(QueueDepth);
    localparam logic [PtrW-1:0] LastPtr  = PtrW'(QueueDepth - 1);

    u16u8_entry_t    slot_reg [QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;

    assign full       = (count_reg == DepthCnt);
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/u16u8_back.sv
// Back part: steps through the bytes of the queue head into a registered output.
// Depends on u16u8_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u16u8_back (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    head_valid,
    input  wire u16u8_pkg::u16u8_entry_t head_entry,
    output logic                         pop,
    output logic                         byte_valid,
    input  wire logic                    byte_stall,
    output logic [7:0]                   utf8_byte,
    output logic                         run_last,
    output logic                         string_last
);
    import u16u8_pkg::*;

    logic        phase_reg;      // 0: held surrogate part (if any), 1: main part
    logic        phase_next;
    logic [1:0]  k_reg;
    logic [1:0]  k_next;
    logic        valid_reg;
    logic        valid_next;
    logic [7:0]  byte_reg;
    logic        run_last_reg;
    logic        string_last_reg;
    logic        load;
    logic        seg_held;
    logic [20:0] seg_cp;
    logic [1:0]  seg_li;
    logic        seg_last;
    logic        item_last;

    // Select the current segment of the head entry
    assign load      = !valid_reg || !byte_stall;
    assign seg_held  = head_entry.has_held && !phase_reg;
    assign seg_cp    = seg_held ? {5'b00000, HighSurrTag, head_entry.held_bits}
                                : head_entry.main_cp;
    assign seg_li    = seg_held ? 2'd2 : last_idx(head_entry.main_cp);
    assign seg_last  = (k_reg == seg_li);
    assign item_last = seg_last && (!seg_held || !head_entry.has_main);
    assign pop       = head_valid && load && item_last;

    // Advance byte index and segment
    always_comb
    begin
        phase_next = phase_reg;
        k_next     = k_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = head_valid;
            if (head_valid) begin
                if (seg_last) begin
                    k_next     = 2'd0;
                    phase_next = !item_last;
                end else begin
                    k_next = k_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= 1'b0;
            k_reg     <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            k_reg     <= k_next;
            valid_reg <= valid_next;
        end
    end

    // Load output payload
    always_ff @(posedge clk)
    begin
        if (load && head_valid) begin
            byte_reg        <= enc_byte(seg_cp, seg_li, k_reg);
            run_last_reg    <= item_last;
            string_last_reg <= item_last && head_entry.eos;
        end
    end

    assign byte_valid  = valid_reg;
    assign utf8_byte   = byte_reg;
    assign run_last    = run_last_reg;
    assign string_last = string_last_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/utf16_to_utf8_encoder_unit.sv
// UTF-16 to UTF-8 encoder, top level.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue and u16u8_back.
//
// Input channel: code_valid / code_stall with code_unit and end_of_string,
// one UTF-16 code unit per item. Output channel: byte_valid / byte_stall with
// utf8_byte, run_last (last byte caused by one input item) and string_last
// (last byte of the string). Both sides use valid/stall: an item moves at an
// edge where valid is high and stall is low.
// A high surrogate that is not at the end of the string is held and gives no
// bytes until the next unit arrives; a following low surrogate completes a
// four-byte sequence, otherwise the held unit goes out as three bytes first.
// Each accepted item is registered in the queue before its first byte is loaded into the output register.
// The output register sends one byte per cycle while byte_stall is low; an item
// gives 1 to 3 bytes for a basic-plane unit, 4 for a surrogate pair, and up to
// 6 when a held surrogate is flushed ahead of a unit.
// A two-entry queue between front and back keeps input flowing while bytes
// drain; code_stall rises only when that queue is full.
// Reset clears the held surrogate, the queue and the output valid.
// While byte_stall is high and a byte is valid, the output byte holds and the back part waits.
`timescale 1ns / 1ps
`default_nettype none

module utf16_to_utf8_encoder_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        code_valid,
    output logic             code_stall,
    input  wire logic [15:0] code_unit,
    input  wire logic        end_of_string,
    output logic             byte_valid,
    input  wire logic        byte_stall,
    output logic [7:0]       utf8_byte,
    output logic             run_last,
    output logic             string_last
);
    import u16u8_pkg::*;

    logic         q_full;
    logic         q_push;
    logic         q_pop;
    logic         head_valid;
    u16u8_entry_t push_entry;
    u16u8_entry_t head_entry;

    // Classify incoming units
    u16u8_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .code_valid    (code_valid),
        .code_stall    (code_stall),
        .code_unit     (code_unit),
        .end_of_string (end_of_string),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (push_entry)
    );

    // Decouple front and back
    u16u8_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // Emit bytes
    u16u8_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_entry  (head_entry),
        .pop         (q_pop),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .utf8_byte   (utf8_byte),
        .run_last    (run_last),
        .string_last (string_last)
    );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for utf16_to_utf8_encoder_unit: a directed table, then random strings.
// Checks every output byte against typed-row bytes or an internal UTF-16 to UTF-8 encoder; depends on u16u8_pkg.
`timescale 1ns / 1ps

module tb_top;

    import u16u8_pkg::*;

    // One stimulus row; typed rows carry their own expected bytes
    typedef struct packed {
        logic [15:0]      unit;
        logic             eos;
        logic             typed;
        logic [2:0]       count;
        logic [0:5][7:0]  bytes;
    } stim_row_t;

    // One expected output item
    typedef struct packed {
        logic [7:0] value;
        logic       run_end;
        logic       str_end;
    } utf8_out_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        code_valid = 1'b0;
    logic        code_stall;
    logic [15:0] code_unit = 16'h0000;
    logic        end_of_string = 1'b0;
    logic        byte_valid;
    logic        byte_stall = 1'b0;
    logic [7:0]  utf8_byte;
    logic        run_last;
    logic        string_last;

    // Expectation carried alongside the payload for typed rows
    logic             row_typed = 1'b0;
    logic [2:0]       row_count = 3'd0;
    logic [0:5][7:0]  row_bytes = '0;

    // Encoder state mirrored by the testbench
    logic [9:0]  held_bits = 10'd0;
    logic        held_on = 1'b0;
    logic [7:0]  unit_bytes[$];
    utf8_out_t   pending_bytes[$];

    int unsigned units_sent = 0;
    int unsigned units_taken = 0;
    int unsigned fail_count = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned stall_pct = 0;

    stim_row_t   directed_rows[0:23];

    utf16_to_utf8_encoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .code_valid    (code_valid),
        .code_stall    (code_stall),
        .code_unit     (code_unit),
        .end_of_string (end_of_string),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .utf8_byte     (utf8_byte),
        .run_last      (run_last),
        .string_last   (string_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Add one byte to the end of the current unit's bytes
    function automatic void append_byte(input logic [7:0] b);
        unit_bytes.insert(unit_bytes.size(), b);
    endfunction

    // Append the UTF-8 bytes of one code point
    function automatic void encode_point(input logic [20:0] cp);
        if (cp < 21'h80)
        begin
            append_byte(cp[7:0]);
        end
        else if (cp < 21'h800)
        begin
            append_byte(Lead2 | 8'(cp[10:6]));
            append_byte(Cont | 8'(cp[5:0]));
        end
        else if (cp < 21'h10000)
        begin
            append_byte(Lead3 | 8'(cp[15:12]));
            append_byte(Cont | 8'(cp[11:6]));
            append_byte(Cont | 8'(cp[5:0]));
        end
        else
        begin
            append_byte(Lead4 | 8'(cp[20:18]));
            append_byte(Cont | 8'(cp[17:12]));
            append_byte(Cont | 8'(cp[11:6]));
            append_byte(Cont | 8'(cp[5:0]));
        end
    endfunction

    // Work out the bytes of one code unit and advance the held surrogate
    function automatic void encode_unit(input logic [15:0] unit, input logic eos);
        logic is_high;
        logic is_low;
        logic paired;
        is_high = (unit[15:10] == HighSurrTag);
        is_low  = (unit[15:10] == LowSurrTag);
        paired  = 1'b0;
        unit_bytes.delete();
        if (held_on)
        begin
            if (is_low)
            begin
                encode_point(SuppBase + {1'b0, held_bits, unit[9:0]});
                paired = 1'b1;
            end
            else
            begin
                encode_point({5'b00000, HighSurrTag, held_bits});
            end
            held_on   = 1'b0;
            held_bits = 10'd0;
        end
        if (!paired)
        begin
            if (is_high && !eos)
            begin
                held_bits = unit[9:0];
                held_on   = 1'b1;
            end
            else
            begin
                encode_point({5'b00000, unit});
            end
        end
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endfunction

    function automatic stim_row_t plain(input logic [15:0] unit, input logic eos);
        stim_row_t r;
        r = '0;
        r.unit = unit;
        r.eos = eos;
        return r;
    endfunction

    // Predict on each accepted item, check each accepted byte
    always @(posedge clk)
    begin : check_proc
        utf8_out_t want;
        int k;
        if (rst_n && code_valid && !code_stall)
        begin
            encode_unit(code_unit, end_of_string);
            if (row_typed)
            begin
                unit_bytes.delete();
                for (k = 0; k < row_count; k++)
                begin
                    append_byte(row_bytes[k]);
                end
            end
            for (k = 0; k < unit_bytes.size(); k++)
            begin
                want.value   = unit_bytes[k];
                want.run_end = (k == unit_bytes.size() - 1);
                want.str_end = want.run_end && end_of_string;
                pending_bytes.insert(pending_bytes.size(), want);
            end
            units_taken++;
        end
        if (rst_n && byte_valid && !byte_stall)
        begin
            if (pending_bytes.size() == 0)
            begin
                note_failure($sformatf("unexpected byte %02h run_last %0b string_last %0b",
                                       utf8_byte, run_last, string_last));
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (want != {utf8_byte, run_last, string_last})
                begin
                    note_failure($sformatf(
                        "expected %02h run_last %0b string_last %0b, got %02h %0b %0b",
                        want.value, want.run_end, want.str_end,
                        utf8_byte, run_last, string_last));
                end
            end
        end
    end

    // Stall the output at random
    always @(posedge clk)
    begin
        byte_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end

    // Offer one item, with random idle cycles ahead of it, and hold it until taken
    task automatic send_unit(input stim_row_t r);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            code_valid <= 1'b0;
            @(posedge clk);
        end
        code_valid    <= 1'b1;
        code_unit     <= r.unit;
        end_of_string <= r.eos;
        row_typed     <= r.typed;
        row_count     <= r.count;
        row_bytes     <= r.bytes;
        units_sent++;
        do
        begin
            @(posedge clk);
        end
        while (code_stall !== 1'b0);
    endtask

    function automatic logic [15:0] bmp_unit();
        logic [15:0] u;
        case ($urandom_range(0, 2))
            0: u = 16'($urandom_range(16'h0000, 16'h007F));
            1: u = 16'($urandom_range(16'h0080, 16'h07FF));
            default:
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    u = 16'($urandom_range(16'h0800, 16'hD7FF));
                end
                else
                begin
                    u = 16'($urandom_range(16'hE000, 16'hFFFF));
                end
            end
        endcase
        return u;
    endfunction

    // Send one string: mostly valid content, some unpaired surrogates and raw units
    task automatic send_random_string();
        int len;
        int k;
        int kind;
        logic last;
        len = $urandom_range(1, 8);
        for (k = 0; k < len; k++)
        begin
            last = (k == len - 1);
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                send_unit(plain(bmp_unit(), last));
            end
            else if (kind < 80)
            begin
                send_unit(plain({HighSurrTag, 10'($urandom_range(0, 1023))}, 1'b0));
                send_unit(plain({LowSurrTag, 10'($urandom_range(0, 1023))}, last));
            end
            else if (kind < 88)
            begin
                send_unit(plain({LowSurrTag, 10'($urandom_range(0, 1023))}, last));
            end
            else if (kind < 96)
            begin
                send_unit(plain({HighSurrTag, 10'($urandom_range(0, 1023))}, last));
            end
            else
            begin
                send_unit(plain(16'($urandom_range(0, 16'hFFFF)), last));
            end
        end
    endtask

    // Run limit
    initial
    begin
        #5_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned idle_by_phase[0:3];
        int unsigned stall_by_phase[0:3];
        int unsigned phase_end;
        int p;
        int i;

        idle_by_phase  = '{0, 83, 0, 35};
        stall_by_phase = '{0, 0, 83, 35};

        // unit, end flag, typed, byte count, bytes
        directed_rows = '{
            '{16'h0000, 1'b0, 1'b1, 3'd1, 48'h00_00_00_00_00_00},
            '{16'h007F, 1'b0, 1'b1, 3'd1, 48'h7F_00_00_00_00_00},
            '{16'h0080, 1'b0, 1'b1, 3'd2, 48'hC2_80_00_00_00_00},
            '{16'h07FF, 1'b0, 1'b1, 3'd2, 48'hDF_BF_00_00_00_00},
            '{16'h0800, 1'b0, 1'b1, 3'd3, 48'hE0_A0_80_00_00_00},
            '{16'hFFFF, 1'b1, 1'b1, 3'd3, 48'hEF_BF_BF_00_00_00},
            // lowest pair, then highest pair
            '{16'hD800, 1'b0, 1'b1, 3'd0, 48'h00_00_00_00_00_00},
            '{16'hDC00, 1'b0, 1'b1, 3'd4, 48'hF0_90_80_80_00_00},
            '{16'hDBFF, 1'b0, 1'b1, 3'd0, 48'h00_00_00_00_00_00},
            '{16'hDFFF, 1'b1, 1'b1, 3'd4, 48'hF4_8F_BF_BF_00_00},
            // lone low surrogates
            '{16'hDC00, 1'b0, 1'b1, 3'd3, 48'hED_B0_80_00_00_00},
            '{16'hDFFF, 1'b0, 1'b1, 3'd3, 48'hED_BF_BF_00_00_00},
            // high surrogate at the end of the string
            '{16'hD800, 1'b1, 1'b1, 3'd3, 48'hED_A0_80_00_00_00},
            // held surrogate followed by a plain unit
            '{16'hDBFF, 1'b0, 1'b1, 3'd0, 48'h00_00_00_00_00_00},
            '{16'h0041, 1'b0, 1'b1, 3'd4, 48'hED_AF_BF_41_00_00},
            // held surrogate followed by another high surrogate
            '{16'hD834, 1'b0, 1'b0, 3'd0, 48'h0},
            '{16'hD800, 1'b0, 1'b0, 3'd0, 48'h0},
            '{16'hDD1E, 1'b1, 1'b0, 3'd0, 48'h0},
            // held surrogate flushed ahead of a three-byte unit
            '{16'hDBC0, 1'b0, 1'b0, 3'd0, 48'h0},
            '{16'hFFFF, 1'b1, 1'b0, 3'd0, 48'h0},
            // held surrogate, then a high surrogate that ends the string
            '{16'hD801, 1'b0, 1'b0, 3'd0, 48'h0},
            '{16'hD802, 1'b1, 1'b0, 3'd0, 48'h0},
            '{16'h1234, 1'b0, 1'b0, 3'd0, 48'h0},
            '{16'h05A5, 1'b1, 1'b0, 3'd0, 48'h0}
        };

        // Hold reset, then release it
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, no idling
        for (i = 0; i < 24; i++)
        begin
            send_unit(directed_rows[i]);
        end

        // Random strings under each idling and stalling pattern
        for (p = 0; p < 4; p++)
        begin
            sender_idle_pct = idle_by_phase[p];
            stall_pct       = stall_by_phase[p];
            phase_end       = units_sent + 105;
            while (units_sent < phase_end)
            begin
                send_random_string();
            end
        end

        // Drain the output, then keep checking for stray bytes
        code_valid <= 1'b0;
        stall_pct = 0;
        while (units_taken != units_sent || pending_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("tb_top OK");
        end
        else
        begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
